// ===== design/riff_wave_header_parser_unit_defines.svh =====
// Assertion macros used by the RIFF/WAVE header parser RTL.
`ifndef RIFF_WAVE_HEADER_PARSER_UNIT_DEFINES_SVH
`define RIFF_WAVE_HEADER_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge outside reset.
`define RWHP_ASSERT_ALWAYS(lbl, clk_sig, rst_n_sig, cond) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (cond)) \
		else $error("rwhp assertion failed");
// Checks that a consequence holds whenever its antecedent is seen.
`define RWHP_ASSERT_IMPLY(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("rwhp implication failed");
`else
`define RWHP_ASSERT_ALWAYS(lbl, clk_sig, rst_n_sig, cond)
`define RWHP_ASSERT_IMPLY(lbl, clk_sig, rst_n_sig, ante, cons)
`endif
`endif

// ===== design/rwhp_pkg.sv =====
// Types and constants of the RIFF/WAVE header parser.
package rwhp_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_final;
	} item_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        header_ready;
		logic [1:0]  format_code;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [31:0] sample_count;
		logic [2:0]  status;
		logic        end_flag;
	} result_t;

	localparam logic [3:0] PH_RIFF      = 4'd0;
	localparam logic [3:0] PH_SEEK_FMT  = 4'd1;
	localparam logic [3:0] PH_SKIP_FMT  = 4'd2;
	localparam logic [3:0] PH_FMT_BODY  = 4'd3;
	localparam logic [3:0] PH_SEEK_DATA = 4'd4;
	localparam logic [3:0] PH_SKIP_DATA = 4'd5;
	localparam logic [3:0] PH_PAYLOAD   = 4'd6;
	localparam logic [3:0] PH_DONE      = 4'd7;
	localparam logic [3:0] PH_ERROR     = 4'd8;

	localparam logic [2:0] ST_BUSY      = 3'd0;
	localparam logic [2:0] ST_OK        = 3'd1;
	localparam logic [2:0] ST_BAD_RIFF  = 3'd2;
	localparam logic [2:0] ST_NO_FMT    = 3'd3;
	localparam logic [2:0] ST_NOT_PCM   = 3'd4;
	localparam logic [2:0] ST_NO_DATA   = 3'd5;
	localparam logic [2:0] ST_TRUNCATED = 3'd6;

	localparam logic [31:0] TAG_RIFF = {8'h52, 8'h49, 8'h46, 8'h46};
	localparam logic [31:0] TAG_WAVE = {8'h57, 8'h41, 8'h56, 8'h45};
	localparam logic [31:0] TAG_FMT  = {8'h66, 8'h6d, 8'h74, 8'h20};
	localparam logic [31:0] TAG_DATA = {8'h64, 8'h61, 8'h74, 8'h61};

	localparam logic [31:0] PCM_FORMAT = 32'd1;
	localparam logic [31:0] FMT_BODY_LEN = 32'd16;

endpackage

// ===== design/rwhp_parse.sv =====
// Parser state and the per-byte field update that forms one result.
module rwhp_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  rwhp_pkg::item_t   item,
	output rwhp_pkg::result_t result
);

	logic [3:0]  phase_q, phase_n;
	logic [4:0]  bif_q, bif_n;
	logic [31:0] skip_q, skip_n;
	logic [31:0] tag_q, tag_n;
	logic [31:0] size_q, size_n;
	logic [15:0] chan_q, chan_n;
	logic [31:0] rate_q, rate_n;
	logic [15:0] bits_q, bits_n;
	logic [31:0] drem_q, drem_n;
	logic [2:0]  err_q, err_n;

	logic [7:0]  b;
	logic        fin;
	logic        stereo;
	logic        wide;

	assign b      = item.in_byte;
	assign fin    = item.is_final;
	assign stereo = (chan_q == 16'd2);
	assign wide   = (bits_q != 16'd8);

	always_comb begin
		phase_n = phase_q;
		bif_n   = bif_q;
		skip_n  = skip_q;
		tag_n   = tag_q;
		size_n  = size_q;
		chan_n  = chan_q;
		rate_n  = rate_q;
		bits_n  = bits_q;
		drem_n  = drem_q;
		err_n   = err_q;
		result  = '0;
		result.end_flag = fin;

		unique case (phase_q)
			rwhp_pkg::PH_RIFF: begin
				tag_n = {tag_q[23:0], b};
				if (bif_q == 5'd3 && tag_n != rwhp_pkg::TAG_RIFF) begin
					err_n   = rwhp_pkg::ST_BAD_RIFF;
					phase_n = rwhp_pkg::PH_ERROR;
				end else if (bif_q >= 5'd11) begin
					if (tag_n != rwhp_pkg::TAG_WAVE) begin
						err_n   = rwhp_pkg::ST_BAD_RIFF;
						phase_n = rwhp_pkg::PH_ERROR;
					end else begin
						phase_n = rwhp_pkg::PH_SEEK_FMT;
						bif_n   = '0;
					end
				end else begin
					bif_n = bif_q + 5'd1;
				end
			end
			rwhp_pkg::PH_SEEK_FMT, rwhp_pkg::PH_SEEK_DATA: begin
				// Bytes 0..3 carry the tag, bytes 4..7 the little-endian size.
				if (!bif_q[2]) begin
					tag_n = {tag_q[23:0], b};
				end else begin
					unique case (bif_q[1:0])
						2'd0: size_n = {24'd0, b};
						2'd1: size_n[15:8] = b;
						2'd2: size_n[23:16] = b;
						2'd3: size_n[31:24] = b;
					endcase
				end
				if (bif_q >= 5'd7) begin
					bif_n = '0;
					// A chunk header that ends on the last byte is not taken as found.
					if (!fin) begin
						if (phase_q == rwhp_pkg::PH_SEEK_FMT && tag_q == rwhp_pkg::TAG_FMT) begin
							phase_n = rwhp_pkg::PH_FMT_BODY;
						end else if (phase_q == rwhp_pkg::PH_SEEK_DATA
								&& tag_q == rwhp_pkg::TAG_DATA) begin
							result.header_ready  = 1'b1;
							result.format_code   = {stereo, wide};
							result.channel_count = chan_q;
							result.sample_rate   = rate_q;
							result.sample_count  = size_n >> ({1'b0, stereo} + {1'b0, wide});
							drem_n  = size_n;
							phase_n = (size_n == 32'd0) ? rwhp_pkg::PH_DONE
								: rwhp_pkg::PH_PAYLOAD;
						end else if (size_n != 32'd0) begin
							skip_n  = size_n;
							phase_n = (phase_q == rwhp_pkg::PH_SEEK_FMT) ? rwhp_pkg::PH_SKIP_FMT
								: rwhp_pkg::PH_SKIP_DATA;
						end
					end
				end else begin
					bif_n = bif_q + 5'd1;
				end
			end
			rwhp_pkg::PH_SKIP_FMT, rwhp_pkg::PH_SKIP_DATA: begin
				skip_n = skip_q - 32'd1;
				if (skip_n == 32'd0) begin
					phase_n = (phase_q == rwhp_pkg::PH_SKIP_FMT) ? rwhp_pkg::PH_SEEK_FMT
						: rwhp_pkg::PH_SEEK_DATA;
				end
			end
			rwhp_pkg::PH_FMT_BODY: begin
				unique case (bif_q)
					5'd0: tag_n = {24'd0, b};
					5'd1: begin
						if ((tag_q | {16'd0, b, 8'd0}) != rwhp_pkg::PCM_FORMAT) begin
							err_n   = rwhp_pkg::ST_NOT_PCM;
							phase_n = rwhp_pkg::PH_ERROR;
						end
					end
					5'd2: chan_n = {8'd0, b};
					5'd3: chan_n[15:8] = b;
					5'd4: rate_n = {24'd0, b};
					5'd5: rate_n[15:8] = b;
					5'd6: rate_n[23:16] = b;
					5'd7: rate_n[31:24] = b;
					5'd14: bits_n = {8'd0, b};
					5'd15: bits_n[15:8] = b;
					default: ;
				endcase
				if (phase_n != rwhp_pkg::PH_ERROR) begin
					if (bif_q >= 5'd15) begin
						bif_n   = '0;
						skip_n  = (size_q > rwhp_pkg::FMT_BODY_LEN)
							? size_q - rwhp_pkg::FMT_BODY_LEN : 32'd0;
						phase_n = (skip_n != 32'd0) ? rwhp_pkg::PH_SKIP_DATA
							: rwhp_pkg::PH_SEEK_DATA;
					end else begin
						bif_n = bif_q + 5'd1;
					end
				end
			end
			rwhp_pkg::PH_PAYLOAD: begin
				result.payload_valid = 1'b1;
				result.payload_byte  = b;
				drem_n = drem_q - 32'd1;
				if (drem_n == 32'd0) begin
					phase_n = rwhp_pkg::PH_DONE;
				end
			end
			default: ;
		endcase

		if (phase_n == rwhp_pkg::PH_ERROR) begin
			result.status = err_n;
		end else if (phase_n == rwhp_pkg::PH_DONE) begin
			result.status = rwhp_pkg::ST_OK;
		end else if (fin) begin
			unique case (phase_n)
				rwhp_pkg::PH_RIFF: result.status = rwhp_pkg::ST_BAD_RIFF;
				rwhp_pkg::PH_SEEK_FMT, rwhp_pkg::PH_SKIP_FMT: result.status = rwhp_pkg::ST_NO_FMT;
				rwhp_pkg::PH_PAYLOAD: result.status = rwhp_pkg::ST_TRUNCATED;
				default: result.status = rwhp_pkg::ST_NO_DATA;
			endcase
		end

		// The last byte of a file returns everything to reset for the next file.
		if (fin) begin
			phase_n = rwhp_pkg::PH_RIFF;
			bif_n   = '0;
			skip_n  = '0;
			tag_n   = '0;
			size_n  = '0;
			chan_n  = '0;
			rate_n  = '0;
			bits_n  = '0;
			drem_n  = '0;
			err_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rwhp_pkg::PH_RIFF;
			bif_q   <= '0;
			skip_q  <= '0;
			tag_q   <= '0;
			size_q  <= '0;
			chan_q  <= '0;
			rate_q  <= '0;
			bits_q  <= '0;
			drem_q  <= '0;
			err_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			bif_q   <= bif_n;
			skip_q  <= skip_n;
			tag_q   <= tag_n;
			size_q  <= size_n;
			chan_q  <= chan_n;
			rate_q  <= rate_n;
			bits_q  <= bits_n;
			drem_q  <= drem_n;
			err_q   <= err_n;
		end
	end

endmodule

// ===== design/riff_wave_header_parser_unit.sv =====
// Each byte passes the input register; its result is offered from the result register.
// One byte per cycle unless the result is stalled; the parser state updates once per byte.
// The input register refills in the same cycle that its byte moves into the result register.
// Reset (arst_n low) empties both registers and returns the parser to the RIFF header phase.
`include "riff_wave_header_parser_unit_defines.svh"
module riff_wave_header_parser_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  rwhp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output rwhp_pkg::result_t result
);

	rwhp_pkg::item_t   item_s1;
	logic              item_valid_s1;
	rwhp_pkg::result_t result_s2;
	logic              result_valid_s2;
	rwhp_pkg::result_t step_result;
	logic              step;

	// A byte is parsed when the result register is free or is emptied this cycle.
	assign step       = item_valid_s1 && (!result_valid_s2 || result_ready);
	assign item_ready = !item_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	rwhp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (step) begin
			result_valid_s2 <= 1'b1;
		end else if (result_ready) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= step_result;
		end
	end

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

	`RWHP_ASSERT_IMPLY(a_payload_not_header, clk, arst_n,
		result_valid && result.payload_valid, !result.header_ready)
	`RWHP_ASSERT_IMPLY(a_fields_zero_without_header, clk, arst_n,
		result_valid && !result.header_ready,
		result.sample_count == 32'd0 && result.channel_count == 16'd0)
	`RWHP_ASSERT_IMPLY(a_final_not_busy, clk, arst_n,
		result_valid && result.end_flag, result.status != rwhp_pkg::ST_BUSY)
	`RWHP_ASSERT_IMPLY(a_payload_status, clk, arst_n,
		result_valid && result.payload_valid,
		result.status == rwhp_pkg::ST_BUSY || result.status == rwhp_pkg::ST_OK
		|| result.status == rwhp_pkg::ST_TRUNCATED)
	`RWHP_ASSERT_IMPLY(a_stalled_input_held, clk, arst_n,
		$past(item_valid_s1) && !$past(item_ready), $stable(item_s1))

endmodule

// ===== test/riff_wave_header_parser_unit_tb.sv =====
// Self-checking testbench of the RIFF/WAVE header parser: directed and random files.
module riff_wave_header_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STREAM_BYTES = 1600;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		rwhp_pkg::item_t it;
		bit              drain;
	} stream_byte_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	rwhp_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	rwhp_pkg::result_t result;

	riff_wave_header_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Byte stream waiting to be sent, and results predicted for bytes already accepted.
	stream_byte_t      file_stream[$];
	rwhp_pkg::result_t predicted_results[$];
	logic [7:0]        file_buf[$];

	int mismatches = 0;
	int bytes_sent = 0;
	int headers_seen = 0;
	int payload_seen = 0;
	int files_ended = 0;
	int endings[8];
	int burst_left = 0;
	int gap_left = 0;
	int stall_tick = 0;
	int idle_cycles = 0;

	// Parser state mirrored by the predictor.
	logic [3:0]  ph;
	logic [4:0]  field_pos;
	logic [31:0] skip_left;
	logic [31:0] tag_sr;
	logic [31:0] size_acc;
	logic [15:0] fmt_channels;
	logic [31:0] fmt_rate;
	logic [15:0] fmt_bits;
	logic [31:0] payload_left;
	logic [2:0]  err_code;

	function automatic void clear_parser();
		ph = rwhp_pkg::PH_RIFF;
		field_pos = '0;
		skip_left = '0;
		tag_sr = '0;
		size_acc = '0;
		fmt_channels = '0;
		fmt_rate = '0;
		fmt_bits = '0;
		payload_left = '0;
		err_code = rwhp_pkg::ST_BUSY;
	endfunction

	function automatic rwhp_pkg::result_t parse_byte(input rwhp_pkg::item_t it);
		rwhp_pkg::result_t r;
		logic [7:0]        b;
		logic [31:0]       b32;
		logic              stereo;
		logic              wide;
		logic [1:0]        shamt;
		r = '0;
		b = it.in_byte;
		b32 = {24'd0, b};
		case (ph)
			rwhp_pkg::PH_RIFF: begin
				tag_sr = {tag_sr[23:0], b};
				if (field_pos == 5'd3 && tag_sr != rwhp_pkg::TAG_RIFF) begin
					err_code = rwhp_pkg::ST_BAD_RIFF;
					ph = rwhp_pkg::PH_ERROR;
				end else if (field_pos >= 5'd11) begin
					if (tag_sr != rwhp_pkg::TAG_WAVE) begin
						err_code = rwhp_pkg::ST_BAD_RIFF;
						ph = rwhp_pkg::PH_ERROR;
					end else begin
						ph = rwhp_pkg::PH_SEEK_FMT;
						field_pos = '0;
					end
				end else begin
					field_pos++;
				end
			end
			rwhp_pkg::PH_SEEK_FMT, rwhp_pkg::PH_SEEK_DATA: begin
				if (field_pos < 5'd4)
					tag_sr = {tag_sr[23:0], b};
				else if (field_pos == 5'd4)
					size_acc = b32;
				else
					size_acc |= b32 << (8 * (field_pos - 5'd4));
				if (field_pos >= 5'd7) begin
					field_pos = '0;
					// A chunk header completed by the last byte of the file does not count.
					if (!it.is_final) begin
						if (ph == rwhp_pkg::PH_SEEK_FMT && tag_sr == rwhp_pkg::TAG_FMT) begin
							ph = rwhp_pkg::PH_FMT_BODY;
						end else if (ph == rwhp_pkg::PH_SEEK_DATA
								&& tag_sr == rwhp_pkg::TAG_DATA) begin
							stereo = (fmt_channels == 16'd2);
							wide = (fmt_bits != 16'd8);
							shamt = {1'b0, stereo} + {1'b0, wide};
							r.header_ready = 1'b1;
							r.format_code = {stereo, wide};
							r.channel_count = fmt_channels;
							r.sample_rate = fmt_rate;
							r.sample_count = size_acc >> shamt;
							payload_left = size_acc;
							ph = (size_acc == '0) ? rwhp_pkg::PH_DONE : rwhp_pkg::PH_PAYLOAD;
						end else if (size_acc != '0) begin
							skip_left = size_acc;
							ph = (ph == rwhp_pkg::PH_SEEK_FMT) ? rwhp_pkg::PH_SKIP_FMT
								: rwhp_pkg::PH_SKIP_DATA;
						end
					end
				end else begin
					field_pos++;
				end
			end
			rwhp_pkg::PH_SKIP_FMT, rwhp_pkg::PH_SKIP_DATA: begin
				skip_left--;
				if (skip_left == '0)
					ph = (ph == rwhp_pkg::PH_SKIP_FMT) ? rwhp_pkg::PH_SEEK_FMT
						: rwhp_pkg::PH_SEEK_DATA;
			end
			rwhp_pkg::PH_FMT_BODY: begin
				case (field_pos)
					5'd0: tag_sr = b32;
					5'd1: begin
						if ((tag_sr | (b32 << 8)) != rwhp_pkg::PCM_FORMAT) begin
							err_code = rwhp_pkg::ST_NOT_PCM;
							ph = rwhp_pkg::PH_ERROR;
						end
					end
					5'd2: fmt_channels = {8'd0, b};
					5'd3: fmt_channels[15:8] = b;
					5'd4: fmt_rate = b32;
					5'd5, 5'd6, 5'd7: fmt_rate |= b32 << (8 * (field_pos - 5'd4));
					5'd14: fmt_bits = {8'd0, b};
					5'd15: fmt_bits[15:8] = b;
					default: ;
				endcase
				if (ph != rwhp_pkg::PH_ERROR) begin
					if (field_pos >= 5'd15) begin
						field_pos = '0;
						skip_left = (size_acc > rwhp_pkg::FMT_BODY_LEN)
							? size_acc - rwhp_pkg::FMT_BODY_LEN : '0;
						ph = (skip_left != '0) ? rwhp_pkg::PH_SKIP_DATA
							: rwhp_pkg::PH_SEEK_DATA;
					end else begin
						field_pos++;
					end
				end
			end
			rwhp_pkg::PH_PAYLOAD: begin
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				payload_left--;
				if (payload_left == '0)
					ph = rwhp_pkg::PH_DONE;
			end
			default: ;
		endcase

		if (ph == rwhp_pkg::PH_ERROR) begin
			r.status = err_code;
		end else if (ph == rwhp_pkg::PH_DONE) begin
			r.status = rwhp_pkg::ST_OK;
		end else if (it.is_final) begin
			case (ph)
				rwhp_pkg::PH_RIFF: r.status = rwhp_pkg::ST_BAD_RIFF;
				rwhp_pkg::PH_SEEK_FMT, rwhp_pkg::PH_SKIP_FMT: r.status = rwhp_pkg::ST_NO_FMT;
				rwhp_pkg::PH_PAYLOAD: r.status = rwhp_pkg::ST_TRUNCATED;
				default: r.status = rwhp_pkg::ST_NO_DATA;
			endcase
		end
		r.end_flag = it.is_final;
		if (it.is_final)
			clear_parser();
		return r;
	endfunction

	// File building.
	task automatic add_byte(input logic [7:0] b);
		file_buf.push_back(b);
	endtask

	task automatic add_le16(input logic [15:0] v);
		add_byte(v[7:0]);
		add_byte(v[15:8]);
	endtask

	task automatic add_le32(input logic [31:0] v);
		add_le16(v[15:0]);
		add_le16(v[31:16]);
	endtask

	task automatic add_tag(input logic [31:0] t);
		add_byte(t[31:24]);
		add_byte(t[23:16]);
		add_byte(t[15:8]);
		add_byte(t[7:0]);
	endtask

	task automatic add_riff();
		add_tag(rwhp_pkg::TAG_RIFF);
		add_le32($urandom);
		add_tag(rwhp_pkg::TAG_WAVE);
	endtask

	task automatic add_chunk(input logic [31:0] t, input logic [31:0] size, input int count);
		add_tag(t);
		add_le32(size);
		repeat (count) add_byte(8'($urandom));
	endtask

	task automatic add_fmt(input logic [31:0] size, input logic [15:0] fmt_code,
			input logic [15:0] channels, input logic [31:0] rate, input logic [15:0] bits);
		add_tag(rwhp_pkg::TAG_FMT);
		add_le32(size);
		add_le16(fmt_code);
		add_le16(channels);
		add_le32(rate);
		add_le32($urandom);
		add_le16(16'($urandom));
		add_le16(bits);
		if (size > rwhp_pkg::FMT_BODY_LEN)
			repeat (size - rwhp_pkg::FMT_BODY_LEN) add_byte(8'($urandom));
	endtask

	task automatic add_data(input logic [31:0] size, input int count);
		add_tag(rwhp_pkg::TAG_DATA);
		add_le32(size);
		repeat (count) add_byte(8'($urandom));
	endtask

	// Moves the file under construction into the stream; its last byte ends the file.
	task automatic send_file(input bit drain);
		stream_byte_t sb;
		for (int i = 0; i < file_buf.size(); i++) begin
			sb.it.in_byte = file_buf[i];
			sb.it.is_final = (i == file_buf.size() - 1);
			sb.drain = drain && (i == 0);
			file_stream.push_back(sb);
		end
		file_buf.delete();
	endtask

	task automatic add_random_file(input bit drain);
		int pick;
		int fsize;
		int dsize;
		int cut;
		logic [15:0] channels;
		logic [15:0] bits;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			// Noise, sometimes behind a valid RIFF tag.
			if ($urandom_range(0, 1))
				add_tag(rwhp_pkg::TAG_RIFF);
			repeat ($urandom_range(1, 30)) add_byte(8'($urandom));
			send_file(drain);
			return;
		end
		add_riff();
		repeat ($urandom_range(0, 2)) begin
			fsize = $urandom_range(0, 5);
			add_chunk($urandom, fsize, fsize);
		end
		pick = $urandom_range(0, 9);
		fsize = (pick < 6) ? 16 : (pick < 9) ? $urandom_range(17, 20) : $urandom_range(0, 15);
		pick = $urandom_range(0, 4);
		channels = (pick < 2) ? 16'd1 : (pick < 4) ? 16'd2 : 16'($urandom);
		pick = $urandom_range(0, 4);
		bits = (pick < 2) ? 16'd8 : (pick < 4) ? 16'd16 : 16'($urandom);
		add_fmt(fsize, ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'd1, channels,
			$urandom, bits);
		repeat ($urandom_range(0, 2)) begin
			fsize = $urandom_range(0, 5);
			add_chunk($urandom, fsize, fsize);
		end
		dsize = $urandom_range(0, 24);
		add_data(dsize, dsize);
		repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			cut = $urandom_range(0, file_buf.size() - 1);
			file_buf[cut] = file_buf[cut] ^ (8'd1 << $urandom_range(0, 7));
		end else if (pick < 27) begin
			cut = $urandom_range(1, file_buf.size());
			while (file_buf.size() > cut)
				void'(file_buf.pop_back());
		end
		send_file(drain);
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		logic            nv;
		rwhp_pkg::item_t ni;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			burst_left = 0;
			gap_left = 0;
			clear_parser();
		end else begin
			if (item_valid && item_ready) begin
				predicted_results.push_back(parse_byte(item));
				bytes_sent++;
			end
			nv = item_valid && !item_ready;
			ni = item;
			if (!nv) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (file_stream.size() != 0 &&
						!(file_stream[0].drain && predicted_results.size() != 0)) begin
					ni = file_stream[0].it;
					void'(file_stream.pop_front());
					nv = 1'b1;
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 24);
						gap_left = $urandom_range(0, 6);
					end else begin
						burst_left--;
					end
				end
			end
			item_valid <= nv;
			item <= ni;
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Receiver: checks each accepted result and stalls on a pattern that changes mode.
	always @(posedge clk or negedge arst_n) begin
		rwhp_pkg::result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0h", $time, result);
					mismatches++;
				end else begin
					want = predicted_results.pop_front();
					check_field("payload_valid", 32'(want.payload_valid),
						32'(result.payload_valid));
					check_field("payload_byte", 32'(want.payload_byte),
						32'(result.payload_byte));
					check_field("header_ready", 32'(want.header_ready),
						32'(result.header_ready));
					check_field("format_code", 32'(want.format_code), 32'(result.format_code));
					check_field("channel_count", 32'(want.channel_count),
						32'(result.channel_count));
					check_field("sample_rate", want.sample_rate, result.sample_rate);
					check_field("sample_count", want.sample_count, result.sample_count);
					check_field("status", 32'(want.status), 32'(result.status));
					check_field("end_flag", 32'(want.end_flag), 32'(result.end_flag));
					headers_seen += want.header_ready;
					payload_seen += want.payload_valid;
					if (want.end_flag) begin
						files_ended++;
						endings[want.status]++;
					end
				end
			end
			stall_tick++;
			case (stall_tick[9:8])
				2'd0: result_ready <= 1'b1;
				2'd1: result_ready <= ($urandom_range(0, 3) != 0);
				2'd2: result_ready <= (stall_tick % 3 == 0);
				default: result_ready <= $urandom_range(0, 1);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("[riff_wave_header_parser_unit] ERROR");
				$finish;
			end
		end
	end

	initial begin
		// Stereo 16-bit with extreme rate and payload bytes.
		add_tag(rwhp_pkg::TAG_RIFF);
		add_le32(32'hFFFF_FFFF);
		add_tag(rwhp_pkg::TAG_WAVE);
		add_fmt(16, 16'd1, 16'd2, 32'hFFFF_FFFF, 16'd16);
		add_tag(rwhp_pkg::TAG_DATA);
		add_le32(32'd4);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'hA5);
		add_byte(8'h5A);
		send_file(1'b0);
		// Mono 8-bit: skipped chunks, an empty chunk, a long fmt body, bytes after the payload.
		add_riff();
		add_chunk("LIST", 32'd3, 3);
		add_fmt(18, 16'd1, 16'd1, 32'd0, 16'd8);
		add_chunk("fact", 32'd0, 0);
		add_chunk("junk", 32'd2, 2);
		add_data(32'd3, 3);
		add_byte(8'h00);
		add_byte(8'hFF);
		send_file(1'b0);
		// Largest channel count, odd depth, empty data chunk.
		add_riff();
		add_fmt(16, 16'd1, 16'hFFFF, 32'd44100, 16'd24);
		add_data(32'd0, 1);
		send_file(1'b0);
		// Wrong RIFF tag, then wrong WAVE tag.
		add_tag("RIFX");
		add_le16(16'h0000);
		send_file(1'b0);
		add_tag(rwhp_pkg::TAG_RIFF);
		add_le32(32'd0);
		add_tag("WAVF");
		send_file(1'b0);
		// Non-PCM format code.
		add_riff();
		add_fmt(16, 16'd3, 16'd2, 32'd48000, 16'd16);
		add_le32(32'hFFFF_FFFF);
		send_file(1'b0);
		// The data chunk header ends the file, then the fmt chunk header does.
		add_riff();
		add_fmt(16, 16'd1, 16'd2, 32'd8000, 16'd8);
		add_data(32'd5, 0);
		send_file(1'b0);
		add_riff();
		add_tag(rwhp_pkg::TAG_FMT);
		add_le32(32'd16);
		send_file(1'b0);
		// Payload far larger than the file.
		add_riff();
		add_fmt(16, 16'd1, 16'd2, 32'd22050, 16'd8);
		add_data(32'hFFFF_FFFF, 3);
		send_file(1'b0);
		// A chunk with a negative signed size before fmt.
		add_riff();
		add_chunk("junk", 32'h8000_0000, 3);
		send_file(1'b0);
		// The file ends inside the fmt body, inside the RIFF header, and after one byte.
		add_riff();
		add_tag(rwhp_pkg::TAG_FMT);
		add_le32(32'd16);
		repeat (5) add_byte(8'($urandom));
		send_file(1'b0);
		add_tag(rwhp_pkg::TAG_RIFF);
		add_byte(8'h00);
		send_file(1'b0);
		add_byte(8'h00);
		send_file(1'b0);

		// The first random file waits until all directed results are back.
		add_random_file(1'b1);
		while (file_stream.size() < STREAM_BYTES)
			add_random_file($urandom_range(0, 19) == 0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (file_stream.size() != 0 || item_valid)
			@(posedge clk);
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d files in %0d bytes: %0d headers parsed, %0d payload bytes.",
			files_ended, bytes_sent, headers_seen, payload_seen);
		$display("Endings: ok %0d, bad riff %0d, no fmt %0d, not pcm %0d, no data %0d, trunc %0d.",
			endings[rwhp_pkg::ST_OK], endings[rwhp_pkg::ST_BAD_RIFF],
			endings[rwhp_pkg::ST_NO_FMT], endings[rwhp_pkg::ST_NOT_PCM],
			endings[rwhp_pkg::ST_NO_DATA], endings[rwhp_pkg::ST_TRUNCATED]);
		if (mismatches == 0)
			$display("[riff_wave_header_parser_unit] OK");
		else
			$display("[riff_wave_header_parser_unit] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/rwhp_pkg.sv
design/rwhp_parse.sv
design/riff_wave_header_parser_unit.sv
test/riff_wave_header_parser_unit_tb.sv
